// File: hw/rtl/sss_pkg.sv
// Package for the SMS send sequencer: command, response, action and phase
// codes, request word layout, queue control structs and reset constants.
// No dependencies.
package sss_pkg;

  localparam int unsigned QueueDepthDef = 8;

  localparam logic [15:0] ModeTimeoutRst   = 16'd2000;
  localparam logic [15:0] PromptTimeoutRst = 16'd5000;
  localparam logic [15:0] ResultTimeoutRst = 16'd15000;

  localparam logic [15:0] ElapsedMax = 16'hFFFF;
  localparam logic [3:0]  AttemptMax = 4'd15;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_ENQ  = 2'd1,
    CMD_RESP = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    RESP_OK      = 2'd0,
    RESP_PROMPT  = 2'd1,
    RESP_CONFIRM = 2'd2,
    RESP_ERROR   = 2'd3
  } resp_e;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_ACCEPTED = 3'd1,
    ACT_FULL     = 3'd2,
    ACT_MODE     = 3'd3,
    ACT_RECIP    = 3'd4,
    ACT_PAYLOAD  = 3'd5,
    ACT_SENT     = 3'd6,
    ACT_FAILED   = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    CFG_MODE_TIMEOUT   = 2'd0,
    CFG_PROMPT_TIMEOUT = 2'd1,
    CFG_RESULT_TIMEOUT = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_MODE   = 4'b0010,
    PH_PROMPT = 4'b0100,
    PH_RESULT = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [3:0] limit;
    logic [7:0] handle;
  } req_word_t;

  typedef struct packed {
    logic      push;
    logic      pop;
    req_word_t wdata;
  } q_ctrl_t;

  typedef struct packed {
    logic      empty;
    logic      full;
    req_word_t head;
  } q_stat_t;

endpackage

// File: hw/rtl/sss_intf.sv
// Channel interfaces of the SMS send sequencer: request input, result output
// and configuration write. Each has a source and a sink modport. No dependencies.
interface sss_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] msg_handle;
  logic [3:0] max_attempts;
  logic [1:0] response_code;

  modport source (output valid, command, msg_handle, max_attempts, response_code,
                  input ready);
  modport sink (input valid, command, msg_handle, max_attempts, response_code,
                output ready);
endinterface

interface sss_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] out_handle;
  logic [3:0] attempts_used;
  logic [2:0] queue_count;
  logic       busy_res;

  modport source (output valid, action, out_handle, attempts_used, queue_count,
                  busy_res, input ready);
  modport sink (input valid, action, out_handle, attempts_used, queue_count,
                busy_res, output ready);
endinterface

interface sss_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/sss_queue.sv
// Ring queue of pending send requests, holding at most QUEUE_DEPTH-1 entries.
// Uses sss_pkg. Storage is a memory with a registered head read and write bypass.
module sss_queue
  import sss_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  q_ctrl_t                        ctrl_i,
  output q_stat_t                        stat_o,
  output logic [$clog2(QUEUE_DEPTH)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [PtrW:0]   DepthW  = (PtrW + 1)'(QUEUE_DEPTH);

  req_word_t       mem_q [QUEUE_DEPTH];
  req_word_t       head_q;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_next, wr_next;
  logic [PtrW:0]   diff;

  assign rd_next = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
  assign wr_next = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;

  assign rd_ptr_d = ctrl_i.pop  ? rd_next : rd_ptr_q;
  assign wr_ptr_d = ctrl_i.push ? wr_next : wr_ptr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[wr_ptr_q] <= ctrl_i.wdata;
    end
  end

  // The head register follows the next read pointer; a write to that same
  // entry in this cycle is forwarded so a fresh entry can start right away.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && (wr_ptr_q == rd_ptr_d)) begin
      head_q <= ctrl_i.wdata;
    end else begin
      head_q <= mem_q[rd_ptr_d];
    end
  end

  always_comb begin
    if (wr_ptr_q >= rd_ptr_q) begin
      diff = {1'b0, wr_ptr_q} - {1'b0, rd_ptr_q};
    end else begin
      diff = {1'b0, wr_ptr_q} + DepthW - {1'b0, rd_ptr_q};
    end
  end

  assign count_o      = diff[PtrW-1:0];
  assign stat_o.empty = (rd_ptr_q == wr_ptr_q);
  assign stat_o.full  = (wr_next == rd_ptr_q);
  assign stat_o.head  = head_q;

endmodule

// File: hw/rtl/sms_send_sequencer_with_retry.sv
// Top level of the SMS send sequencer with retry: phase control, timeouts,
// attempt counting and the result register. Uses sss_pkg, sss_intf, sss_queue.
//
//   channel   dir  handshake     payload
//   req_i     in   valid/ready   command, msg_handle, max_attempts, response_code
//   res_o     out  valid/ready   action, out_handle, attempts_used, queue_count, busy_res
//   cfg_i     in   valid/ready   index, data (three 16-bit timeout registers)
//
// Each item is processed in the cycle it is accepted and its result is in the
// result register in the next cycle; one item per cycle is sustained but for stalls.
// The input stalls only while a result waits in the result register and the
// output side holds ready low in that same cycle.
// Reset is asynchronous and needs no clearing pass; the configuration port is
// always ready.
module sms_send_sequencer_with_retry
  import sss_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sss_req_if.sink   req_i,
  sss_res_if.source res_o,
  sss_cfg_if.sink   cfg_i
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  logic [15:0] mode_to_q, prompt_to_q, result_to_q;

  phase_e      phase_q, phase_d;
  logic [3:0]  att_q, att_d;
  req_word_t   cur_q, cur_d;
  logic [15:0] el_q, el_d;

  q_ctrl_t         qctl;
  q_stat_t         qst;
  logic [PtrW-1:0] qcnt;
  logic [PtrW-1:0] qcnt_after;
  logic [PtrW+2:0] qcnt_ext;

  logic        accept;
  action_e     act_d;
  logic [15:0] el_inc;
  logic [3:0]  att_inc;
  logic        att_hit;
  logic        busy_d;
  logic [7:0]  handle_d;
  logic [3:0]  att_out_d;

  logic        res_valid_q;
  logic [2:0]  res_action_q;
  logic [7:0]  res_handle_q;
  logic [3:0]  res_att_q;
  logic [2:0]  res_qcnt_q;
  logic        res_busy_q;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_to_q   <= ModeTimeoutRst;
      prompt_to_q <= PromptTimeoutRst;
      result_to_q <= ResultTimeoutRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MODE_TIMEOUT:   mode_to_q   <= cfg_i.data;
        CFG_PROMPT_TIMEOUT: prompt_to_q <= cfg_i.data;
        CFG_RESULT_TIMEOUT: result_to_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  sss_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (qctl),
    .stat_o (qst),
    .count_o(qcnt)
  );

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign el_inc  = (el_q == ElapsedMax) ? el_q : el_q + 16'd1;
  assign att_inc = (att_q == AttemptMax) ? att_q : att_q + 4'd1;
  assign att_hit = (att_inc >= cur_q.limit);

  always_comb begin
    phase_d    = phase_q;
    att_d      = att_q;
    cur_d      = cur_q;
    el_d       = el_q;
    act_d      = ACT_NONE;
    qctl.push  = 1'b0;
    qctl.pop   = 1'b0;
    qctl.wdata = '{limit: req_i.max_attempts, handle: req_i.msg_handle};

    if (accept) begin
      case (req_i.command)
        CMD_TICK: begin
          if (phase_q == PH_IDLE) begin
            if (!qst.empty) begin
              cur_d    = qst.head;
              qctl.pop = 1'b1;
              att_d    = '0;
              phase_d  = PH_MODE;
              el_d     = '0;
              act_d    = ACT_MODE;
            end
          end else begin
            el_d = el_inc;
            case (phase_q)
              PH_MODE: begin
                if (el_inc > mode_to_q) begin
                  el_d  = '0;
                  act_d = ACT_MODE;
                end
              end
              PH_PROMPT: begin
                if (el_inc > prompt_to_q) begin
                  att_d = att_inc;
                  if (att_hit) begin
                    phase_d = PH_IDLE;
                    act_d   = ACT_FAILED;
                  end else begin
                    el_d  = '0;
                    act_d = ACT_RECIP;
                  end
                end
              end
              PH_RESULT: begin
                if (el_inc > result_to_q) begin
                  att_d = att_inc;
                  if (att_hit) begin
                    phase_d = PH_IDLE;
                    act_d   = ACT_FAILED;
                  end else begin
                    phase_d = PH_MODE;
                    el_d    = '0;
                    act_d   = ACT_MODE;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        CMD_ENQ: begin
          if (qst.full) begin
            act_d = ACT_FULL;
          end else begin
            qctl.push = 1'b1;
            act_d     = ACT_ACCEPTED;
          end
        end
        CMD_RESP: begin
          case (phase_q)
            PH_MODE: begin
              if (req_i.response_code == RESP_OK) begin
                phase_d = PH_PROMPT;
                el_d    = '0;
                act_d   = ACT_RECIP;
              end
            end
            PH_PROMPT: begin
              if (req_i.response_code == RESP_PROMPT) begin
                phase_d = PH_RESULT;
                el_d    = '0;
                act_d   = ACT_PAYLOAD;
              end
            end
            PH_RESULT: begin
              if (req_i.response_code inside {RESP_CONFIRM, RESP_OK}) begin
                phase_d = PH_IDLE;
                act_d   = ACT_SENT;
              end else if (req_i.response_code == RESP_ERROR) begin
                att_d = att_inc;
                if (att_hit) begin
                  phase_d = PH_IDLE;
                  act_d   = ACT_FAILED;
                end else begin
                  phase_d = PH_MODE;
                  el_d    = '0;
                  act_d   = ACT_MODE;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign busy_d = (phase_d != PH_IDLE);

  always_comb begin
    if ((act_d == ACT_ACCEPTED) || (act_d == ACT_FULL)) begin
      handle_d = req_i.msg_handle;
    end else if ((act_d != ACT_NONE) || busy_d) begin
      handle_d = cur_d.handle;
    end else begin
      handle_d = '0;
    end
  end

  assign att_out_d = (busy_d || (act_d == ACT_SENT) || (act_d == ACT_FAILED)) ? att_d : '0;

  // Queue occupancy after this transfer, reported in its low three bits.
  always_comb begin
    qcnt_after = qcnt;
    if (qctl.push) begin
      qcnt_after = qcnt + 1'b1;
    end else if (qctl.pop) begin
      qcnt_after = qcnt - 1'b1;
    end
  end
  assign qcnt_ext = {3'b000, qcnt_after};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      att_q   <= '0;
      cur_q   <= '0;
      el_q    <= '0;
    end else begin
      phase_q <= phase_d;
      att_q   <= att_d;
      cur_q   <= cur_d;
      el_q    <= el_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (accept) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_action_q <= act_d;
      res_handle_q <= handle_d;
      res_att_q    <= att_out_d;
      res_qcnt_q   <= qcnt_ext[2:0];
      res_busy_q   <= busy_d;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.action        = res_action_q;
  assign res_o.out_handle    = res_handle_q;
  assign res_o.attempts_used = res_att_q;
  assign res_o.queue_count   = res_qcnt_q;
  assign res_o.busy_res      = res_busy_q;

  // The busy flag in a pending result always matches the live phase.
  a_busy_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_busy_q == (phase_q != PH_IDLE)))
    else $error("pending result busy flag disagrees with phase");

  // An active send never has more counted attempts than its limit.
  a_attempts_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (att_q <= cur_q.limit))
    else $error("attempt count exceeds limit while busy");

  // A tick while idle with a waiting request starts it in the mode phase.
  a_tick_starts_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.command == CMD_TICK) && (phase_q == PH_IDLE) && !qst.empty)
    |=> ((phase_q == PH_MODE) && (att_q == 4'd0)))
    else $error("start tick did not enter the mode phase");

endmodule
